// File: rtl/core/ntlv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ntlv_pkg;

  // stack depth and offset range
  localparam int MAX_DEPTH   = 8;
  localparam int OFFSET_BITS = 33;

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = OFFSET_BITS + 1;
  localparam int END_W = ((CNT_W > 32) ? CNT_W : 32) + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MARKER_LEN16 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_LEN32 = 1'd1;

  localparam logic [7:0]  MARKER_LEN16_RST = 8'd254;
  localparam logic [7:0]  MARKER_LEN32_RST = 8'd255;

  localparam logic [7:0]  TAG_LONG_MASK  = 8'h80;
  localparam logic [15:0] TAG_HIGH_MASK  = 16'hFF00;
  localparam logic [15:0] TAG_CONS_LONG  = 16'h4000;
  localparam logic [15:0] TAG_CONS_SHORT = 16'h0040;

  typedef enum logic [1:0] {
    ROLE_HEADER  = 2'd0,
    ROLE_VALUE   = 2'd1,
    ROLE_IGNORED = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    MSG_CONTINUE  = 2'd0,
    MSG_ACCEPTED  = 2'd1,
    MSG_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    role_t       byte_role;
    logic [15:0] tag;
    logic [31:0] element_length;
    logic [3:0]  depth;
    logic        header_done;
    logic        is_constructed;
    logic [7:0]  value_byte;
    logic        element_closed;
    logic [3:0]  levels_closed;
    status_t     message_status;
  } result_t;

  function automatic logic tag_constructed(input logic [15:0] t);
    logic c;
    if ((t & TAG_HIGH_MASK) != 16'd0) c = ((t & TAG_CONS_LONG) != 16'd0);
    else c = ((t & TAG_CONS_SHORT) != 16'd0);
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ntlv_intf.sv
`timescale 1ns / 1ps
`default_nettype none

interface ntlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ntlv_out_if import ntlv_pkg::*; ();
  logic        valid;
  logic        ready;
  role_t       byte_role;
  logic [15:0] tag;
  logic [31:0] element_length;
  logic [3:0]  depth;
  logic        header_done;
  logic        is_constructed;
  logic [7:0]  value_byte;
  logic        element_closed;
  logic [3:0]  levels_closed;
  status_t     message_status;

  modport source (
    output valid, output byte_role, output tag, output element_length, output depth,
    output header_done, output is_constructed, output value_byte,
    output element_closed, output levels_closed, output message_status,
    input ready
  );
  modport sink (
    input valid, input byte_role, input tag, input element_length, input depth,
    input header_done, input is_constructed, input value_byte,
    input element_closed, input levels_closed, input message_status,
    output ready
  );
endinterface

interface ntlv_cfg_if import ntlv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/nested_tlv_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// nested tag-length-value parser, one message byte per transfer
// in_ch  : data_byte plus last_byte, which marks the final byte of a message
// out_ch : one result per input byte - role, tag, length, depth, header and
//          closing flags, the byte itself and the message status
// cfg_ch : writes the two length marker values, always ready, index 0 is the
//          16-bit marker and index 1 the 32-bit marker
// a result appears on out_ch in the cycle after its input transfer
// throughput: one byte per cycle while the receiver keeps up; all parsing for a
//   byte, including the compare of its offset against every open end offset on
//   the stack, sits between the input handshake and the single output register
// when the receiver stalls, the output register holds its result and in_ch
//   takes a new byte only in a cycle in which that result leaves
// reset (rst_n low, synchronous) empties the output register, restores both
//   markers to 254 and 255 and starts a fresh message at offset zero
// after a malformed byte every further byte of that message comes out as
//   ignored; the last byte reports the status and clears the parse state
module nested_tlv_stream_parser import ntlv_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  ntlv_in_if.sink     in_ch,
  ntlv_out_if.source  out_ch,
  ntlv_cfg_if.sink    cfg_ch
);

  // configuration
  logic [7:0] marker16_r;
  logic [7:0] marker32_r;

  // parse state
  logic [2:0]             hc_r,       hc_nxt;
  logic [7:0]             marker_r,   marker_nxt;
  logic [31:0]            len_r,      len_nxt;
  logic [15:0]            tag_r,      tag_nxt;
  logic [END_W-1:0]       vend_r,     vend_nxt;
  logic                   in_value_r, in_value_nxt;
  logic [CNT_W-1:0]       noff_r,     noff_nxt;   // offset of the next byte plus one
  logic [LVL_W-1:0]       level_r,    level_nxt;
  logic                   err_r,      err_nxt;
  logic [OFFSET_BITS-1:0] stack_r [MAX_DEPTH];

  // stack write
  logic                   push;
  logic [OFFSET_BITS-1:0] push_end;

  // output register
  result_t res, res_r;
  logic    out_valid_r;
  logic    in_fire;

  // per-byte working values
  logic [7:0]           b;
  logic [2:0]           tl;
  logic [2:0]           lfs;
  logic [2:0]           hc_inc;
  logic                 done;
  logic [31:0]          hlen;
  logic [31:0]          len_shift;
  logic [END_W-1:0]     elem_end;
  logic                 cons;
  logic                 bad;
  logic                 closed;
  logic [MAX_DEPTH-1:0] match;
  logic [MAX_DEPTH-1:0] beyond;
  logic [LVL_W-1:0]     lv;
  role_t                role;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign b = in_ch.data_byte;

  // length field size from the first length byte
  function automatic logic [2:0] len_size(input logic [7:0] v, input logic [7:0] m16,
                                          input logic [7:0] m32);
    logic [2:0] s;
    if (v == m16) s = 3'd3;
    else if (v == m32) s = 3'd5;
    else s = 3'd1;
    return s;
  endfunction

  // open end offsets equal to this byte's end, or below a new element end
  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      match[i]  = (LVL_W'(i) < level_r) && ({1'b0, stack_r[i]} == noff_r);
      beyond[i] = (LVL_W'(i) < level_r) && (elem_end > END_W'(stack_r[i]));
    end
  end

  assign tl        = tag_r[15] ? 3'd2 : 3'd1;
  assign hc_inc    = hc_r + 3'd1;
  assign len_shift = {len_r[23:0], b};
  assign elem_end  = END_W'(noff_r) + END_W'(hlen);
  assign lv        = LVL_W'($countones(match));

  always_comb begin
    hc_nxt       = hc_r;
    marker_nxt   = marker_r;
    len_nxt      = len_r;
    tag_nxt      = tag_r;
    vend_nxt     = vend_r;
    in_value_nxt = in_value_r;
    noff_nxt     = noff_r;
    level_nxt    = level_r;
    err_nxt      = err_r;
    push         = 1'b0;
    push_end     = elem_end[OFFSET_BITS-1:0];
    bad          = err_r;
    done         = 1'b0;
    hlen         = 32'd0;
    lfs          = len_size(marker_r, marker16_r, marker32_r);
    cons         = 1'b0;
    closed       = 1'b0;
    role         = ROLE_HEADER;

    if (!bad) begin
      if (in_value_r) begin
        role = ROLE_VALUE;
        if (END_W'(noff_r) == vend_r) begin
          closed       = 1'b1;
          in_value_nxt = 1'b0;
        end
      end else begin
        if (hc_r == 3'd0) begin
          tag_nxt = ((b & TAG_LONG_MASK) != 8'd0) ? {b, 8'd0} : {8'd0, b};
          len_nxt = 32'd0;
          hc_nxt  = 3'd1;
        end else if (hc_r < tl) begin
          tag_nxt = tag_r | {8'd0, b};
          hc_nxt  = 3'd2;
        end else if (hc_r == tl) begin
          marker_nxt = b;
          len_nxt    = 32'd0;
          hc_nxt     = hc_inc;
          if (len_size(b, marker16_r, marker32_r) == 3'd1) begin
            done = 1'b1;
            hlen = {24'd0, b};
          end
        end else begin
          len_nxt = len_shift;
          hc_nxt  = hc_inc;
          if (hc_inc >= tl + lfs) begin
            done = 1'b1;
            hlen = len_shift;
          end
        end
        cons = tag_constructed(tag_nxt);
        if (done) begin
          hc_nxt     = 3'd0;
          marker_nxt = 8'd0;
          len_nxt    = hlen;
          if ((elem_end >> OFFSET_BITS) != '0) begin
            bad = 1'b1;
          end else if (|beyond) begin
            bad = 1'b1;               // runs past its parent
          end else if (cons) begin
            if (hlen == 32'd0 || level_r >= LVL_W'(MAX_DEPTH)) begin
              bad = 1'b1;             // empty constructed element or too deep
            end else begin
              push      = 1'b1;
              level_nxt = level_r + LVL_W'(1);
            end
          end else if (hlen == 32'd0) begin
            closed = 1'b1;
          end else begin
            in_value_nxt = 1'b1;
            vend_nxt     = elem_end;
          end
        end
      end

      if (!bad && noff_r[CNT_W-1]) bad = 1'b1;
      // header cut short by its parent's end
      if (!bad && hc_nxt != 3'd0 && (|match)) bad = 1'b1;
      if (!bad) level_nxt = level_nxt - lv;
      if (!bad && in_ch.last_byte && (hc_nxt != 3'd0 || in_value_nxt || level_nxt != '0))
        bad = 1'b1;
      noff_nxt = noff_r + CNT_W'(1);
    end

    res = '0;
    res.value_byte = b;
    if (bad) begin
      err_nxt       = 1'b1;
      res.byte_role = ROLE_IGNORED;
    end else begin
      res.byte_role      = role;
      res.tag            = tag_nxt;
      res.element_length = (role == ROLE_VALUE) ? len_r : (done ? hlen : 32'd0);
      res.depth          = 4'(level_r);
      res.header_done    = done;
      res.is_constructed = cons;
      res.element_closed = closed;
      res.levels_closed  = 4'(lv);
    end
    if (in_ch.last_byte) begin
      res.message_status = bad ? MSG_MALFORMED : MSG_ACCEPTED;
      // fresh message
      hc_nxt       = 3'd0;
      marker_nxt   = 8'd0;
      len_nxt      = 32'd0;
      tag_nxt      = 16'd0;
      vend_nxt     = '0;
      in_value_nxt = 1'b0;
      noff_nxt     = CNT_W'(1);
      level_nxt    = '0;
      err_nxt      = 1'b0;
      push         = 1'b0;
    end else begin
      res.message_status = MSG_CONTINUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker16_r <= MARKER_LEN16_RST;
      marker32_r <= MARKER_LEN32_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MARKER_LEN16: marker16_r <= cfg_ch.data;
        REG_MARKER_LEN32: marker32_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r       <= 3'd0;
      marker_r   <= 8'd0;
      len_r      <= 32'd0;
      tag_r      <= 16'd0;
      vend_r     <= '0;
      in_value_r <= 1'b0;
      noff_r     <= CNT_W'(1);
      level_r    <= '0;
      err_r      <= 1'b0;
    end else if (in_fire) begin
      hc_r       <= hc_nxt;
      marker_r   <= marker_nxt;
      len_r      <= len_nxt;
      tag_r      <= tag_nxt;
      vend_r     <= vend_nxt;
      in_value_r <= in_value_nxt;
      noff_r     <= noff_nxt;
      level_r    <= level_nxt;
      err_r      <= err_nxt;
    end
  end

  // end offset stack, entries read only below the current level
  always_ff @(posedge clk) begin
    if (in_fire && push) stack_r[level_r[IDX_W-1:0]] <= push_end;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) res_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_role      = res_r.byte_role;
  assign out_ch.tag            = res_r.tag;
  assign out_ch.element_length = res_r.element_length;
  assign out_ch.depth          = res_r.depth;
  assign out_ch.header_done    = res_r.header_done;
  assign out_ch.is_constructed = res_r.is_constructed;
  assign out_ch.value_byte     = res_r.value_byte;
  assign out_ch.element_closed = res_r.element_closed;
  assign out_ch.levels_closed  = res_r.levels_closed;
  assign out_ch.message_status = res_r.message_status;

  // stack never grows past its depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(MAX_DEPTH))
    else $error("stack level beyond depth");

  // a value is only open once its header is complete
  a_value_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_value_r |-> (hc_r == 3'd0))
    else $error("value open with partial header");

  // the last byte of a message leaves a clean parse state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last_byte) |=>
      (level_r == '0 && !in_value_r && hc_r == 3'd0 && !err_r && noff_r == CNT_W'(1)))
    else $error("parse state not cleared at message end");

  // ignored bytes carry no element information
  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.byte_role == ROLE_IGNORED) |->
      (res_r.tag == 16'd0 && !res_r.header_done && !res_r.element_closed &&
       res_r.levels_closed == 4'd0 && res_r.element_length == 32'd0))
    else $error("ignored byte reports element fields");

endmodule

`default_nettype wire

// File: tb/nested_tlv_stream_parser_tb.sv
`timescale 1ns / 1ps

module nested_tlv_stream_parser_tb;
  import ntlv_pkg::*;

  localparam logic [63:0] OFF_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int unsigned RUN_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ntlv_in_if  in_ch ();
  ntlv_out_if out_ch ();
  ntlv_cfg_if cfg_ch ();

  nested_tlv_stream_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // byte reports still to come out of the block, oldest first
  result_t expected_reports[$];

  // message under construction by the generator
  logic [7:0] msg_q[$];

  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned parsed_items = 0;

  // idle control shared by sender and receiver
  bit idle_on = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned stall_left = 0;

  // parser state as the testbench sees it
  logic [7:0]  m16;
  logic [7:0]  m32;
  logic [2:0]  hdr_taken;
  logic [47:0] hdr_bits;
  logic [15:0] tag_now;
  logic [63:0] prim_end;
  bit          in_prim;
  logic [63:0] next_off;
  logic [63:0] open_ends[MAX_DEPTH];
  int unsigned open_lvl;
  bit          msg_bad;

  // clock and run limit
  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic void clear_parse();
    hdr_taken = '0;
    hdr_bits  = '0;
    tag_now   = '0;
    prim_end  = '0;
    in_prim   = 1'b0;
    next_off  = '0;
    for (int i = 0; i < MAX_DEPTH; i++) open_ends[i] = '0;
    open_lvl  = 0;
    msg_bad   = 1'b0;
  endfunction

  // how many bytes the length field takes, judged by its first byte
  function automatic int unsigned len_field_bytes(input logic [7:0] first);
    if (first == m16) return 3;
    if (first == m32) return 5;
    return 1;
  endfunction

  function automatic result_t predict_report(input logic [7:0] b, input bit last);
    result_t     r;
    bit          bad, done, hd, cons, closed;
    role_t       role;
    logic [15:0] tg;
    logic [31:0] len;
    logic [3:0]  dep;
    logic [63:0] n, vlen, end_off;
    int unsigned k, tl, closes;
    bad = msg_bad;
    done = 1'b0;
    hd = 1'b0;
    cons = 1'b0;
    closed = 1'b0;
    role = ROLE_HEADER;
    tg = '0;
    len = '0;
    dep = 4'(open_lvl);
    closes = 0;
    vlen = '0;
    n = '0;
    if (!bad) begin
      n = next_off + 64'd1;
      if (in_prim) begin
        role = ROLE_VALUE;
        tg = tag_now;
        len = hdr_bits[31:0];
        if (n == prim_end) begin
          closed = 1'b1;
          in_prim = 1'b0;
        end
      end else begin
        k = hdr_taken;
        if (k == 0) begin
          // first tag byte, top bit selects a two-byte tag
          tag_now = b[7] ? {b, 8'h00} : {8'h00, b};
          hdr_bits = '0;
          hdr_taken = 3'd1;
        end else begin
          tl = tag_now[15] ? 2 : 1;
          if (k < tl) begin
            tag_now[7:0] = b;
            hdr_taken = 3'd2;
          end else if (k == tl) begin
            hdr_bits = {b, 40'd0};
            hdr_taken = 3'(k + 1);
            if (len_field_bytes(b) == 1) begin
              done = 1'b1;
              vlen = {56'd0, b};
            end
          end else begin
            hdr_bits[31:0] = {hdr_bits[23:0], b};
            hdr_taken = 3'(k + 1);
            if (k + 1 >= tl + len_field_bytes(hdr_bits[47:40])) begin
              done = 1'b1;
              vlen = {32'd0, hdr_bits[31:0]};
            end
          end
        end
        tg = tag_now;
        cons = (tag_now[15:8] != 8'd0) ? tag_now[14] : tag_now[6];
        if (done) begin
          end_off = n + vlen;
          hdr_taken = '0;
          hdr_bits = {16'd0, vlen[31:0]};
          hd = 1'b1;
          len = vlen[31:0];
          if (end_off > OFF_LIMIT) bad = 1'b1;
          else if (open_lvl > 0 && end_off > open_ends[open_lvl - 1]) bad = 1'b1;
          else if (cons) begin
            if (vlen == 0 || open_lvl >= MAX_DEPTH) bad = 1'b1;
            else begin
              open_ends[open_lvl] = end_off;
              open_lvl++;
            end
          end else if (vlen == 0) closed = 1'b1;
          else begin
            in_prim = 1'b1;
            prim_end = end_off;
          end
        end
      end
      if (!bad && n > OFF_LIMIT) bad = 1'b1;
      // a parent may not end in the middle of a child header
      if (!bad && hdr_taken != 0 && open_lvl > 0 && open_ends[open_lvl - 1] == n)
        bad = 1'b1;
      while (!bad && open_lvl > 0 && open_ends[open_lvl - 1] == n) begin
        open_lvl--;
        closes++;
      end
      if (!bad && last && (hdr_taken != 0 || in_prim || open_lvl != 0)) bad = 1'b1;
      next_off = n & OFF_LIMIT;
    end

    r = '0;
    r.value_byte = b;
    if (bad) begin
      msg_bad = 1'b1;
      r.byte_role = ROLE_IGNORED;
    end else begin
      r.byte_role      = role;
      r.tag            = tg;
      r.element_length = len;
      r.depth          = dep;
      r.header_done    = hd;
      r.is_constructed = cons;
      r.element_closed = closed;
      r.levels_closed  = 4'(closes);
    end
    if (last) r.message_status = bad ? MSG_MALFORMED : MSG_ACCEPTED;
    else r.message_status = MSG_CONTINUE;
    if (last) clear_parse();
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // message generator
  // ---------------------------------------------------------------------

  // one-byte tags keep bit 7 clear, two-byte tags set it; bit 6 of the first
  // tag byte marks a constructed element either way
  function automatic void push_tag(input bit cons);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = 8'($urandom_range(0, 63));
    lo = 8'($urandom_range(0, 255));
    if (cons) hi[6] = 1'b1;
    if ($urandom_range(0, 2) == 0) begin
      hi[7] = 1'b1;
      msg_q.push_back(hi);
      msg_q.push_back(lo);
    end else begin
      msg_q.push_back(hi);
    end
  endfunction

  // short form unless the value collides with a marker; long forms now and then
  function automatic void push_len(input logic [31:0] len);
    bit short_ok, w16_ok, w32_ok;
    int unsigned pick;
    short_ok = (len <= 255) && (len[7:0] != m16) && (len[7:0] != m32);
    w16_ok = (len <= 65535);
    w32_ok = (m32 != m16);
    pick = $urandom_range(0, 9);
    if (short_ok && pick < 7) begin
      msg_q.push_back(len[7:0]);
    end else if (w32_ok && (pick == 9 || !w16_ok)) begin
      msg_q.push_back(m32);
      msg_q.push_back(len[31:24]);
      msg_q.push_back(len[23:16]);
      msg_q.push_back(len[15:8]);
      msg_q.push_back(len[7:0]);
    end else begin
      msg_q.push_back(m16);
      msg_q.push_back(len[15:8]);
      msg_q.push_back(len[7:0]);
    end
  endfunction

  function automatic void push_primitive();
    int unsigned len;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(6, 40);
    else len = $urandom_range(0, 5);
    push_tag(1'b0);
    push_len(len);
    repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // everything from start_idx on becomes the value of a new constructed element
  function automatic void wrap_constructed(input int unsigned start_idx);
    logic [7:0] body[$];
    while (msg_q.size() > start_idx) body.push_front(msg_q.pop_back());
    push_tag(1'b1);
    push_len(body.size());
    foreach (body[i]) msg_q.push_back(body[i]);
  endfunction

  // well-formed element sequence; a tower opens max_nest levels straight away
  function automatic void build_elements(input int unsigned budget,
                                         input int unsigned max_nest, input bit tower);
    int unsigned starts[$];
    int unsigned kids[$];
    int unsigned nodes;
    int unsigned pick;
    msg_q.delete();
    nodes = 0;
    if (tower) begin
      repeat (max_nest) begin
        starts.push_back(msg_q.size());
        kids.push_back(0);
        nodes++;
      end
    end
    while (nodes < budget || starts.size() > 0) begin
      pick = $urandom_range(0, 9);
      if (nodes >= budget || (starts.size() > 0 && kids[kids.size() - 1] > 0 && pick < 3)) begin
        if (kids[kids.size() - 1] == 0) push_primitive();
        wrap_constructed(starts.pop_back());
        void'(kids.pop_back());
        if (kids.size() > 0) kids[kids.size() - 1]++;
      end else if (starts.size() < max_nest && pick < 6) begin
        starts.push_back(msg_q.size());
        kids.push_back(0);
        nodes++;
      end else begin
        push_primitive();
        if (kids.size() > 0) kids[kids.size() - 1]++;
        nodes++;
      end
    end
  endfunction

  // mostly well-formed messages, the rest broken in one way or another
  function automatic void make_message(input int unsigned deep_pct);
    bit deep;
    int unsigned idx;
    deep = ($urandom_range(0, 99) < deep_pct);
    if ($urandom_range(0, 99) < 75) begin
      build_elements($urandom_range(1, 8), deep ? MAX_DEPTH : 3, deep);
    end else begin
      build_elements($urandom_range(1, 5), 3, 1'b0);
      case ($urandom_range(0, 5))
        0: begin
          // cut short
          if (msg_q.size() > 1)
            repeat ($urandom_range(1, msg_q.size() - 1)) void'(msg_q.pop_back());
        end
        1: begin
          // one byte damaged
          idx = $urandom_range(0, msg_q.size() - 1);
          msg_q[idx] = 8'($urandom_range(0, 255));
        end
        2: begin
          // constructed element with nothing inside
          push_tag(1'b1);
          push_len(0);
        end
        3: begin
          // one level more than the stack holds
          build_elements(MAX_DEPTH + 1, MAX_DEPTH + 1, 1'b1);
        end
        4: begin
          // primitive announcing a huge length
          push_tag(1'b0);
          if (m32 != m16) begin
            msg_q.push_back(m32);
            repeat (4) msg_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            msg_q.push_back(m16);
            msg_q.push_back(8'hFF);
            msg_q.push_back(8'hFF);
          end
          repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          // plain noise
          msg_q.delete();
          repeat ($urandom_range(1, 20)) msg_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_MARKER_LEN16;
    cfg_ch.data     = '0;
  end

  // one byte transfer; the expectation is worked out when the block takes it
  task automatic send_byte(input logic [7:0] b, input bit last);
    result_t r;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.last_byte = last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = predict_report(b, last);
    expected_reports.push_back(r);
    if (r.byte_role != ROLE_IGNORED) parsed_items++;
  endtask

  task automatic send_message();
    logic [7:0] bytes_q[$];
    bytes_q = msg_q;
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // let every report out before touching the markers
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == REG_MARKER_LEN16) m16 = val;
    else m32 = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_markers(input logic [7:0] len16, input logic [7:0] len32);
    drain();
    write_reg(REG_MARKER_LEN16, len16);
    write_reg(REG_MARKER_LEN32, len32);
  endtask

  task automatic run_messages(input int unsigned target, input int unsigned deep_pct,
                              input bit quiet);
    int unsigned first;
    first = parsed_items;
    while (parsed_items - first < target) begin
      idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      make_message(deep_pct);
      send_message();
    end
  endtask

  // receiver: long hold-off when asked, short random stalls otherwise
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // checker
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: report transfer with nothing expected, byte 0x%0h",
                 $time, out_ch.value_byte);
        fail_cnt++;
      end else begin
        want = expected_reports.pop_front();
        check_field("byte_role", 32'(want.byte_role), 32'(out_ch.byte_role));
        check_field("tag", 32'(want.tag), 32'(out_ch.tag));
        check_field("element_length", want.element_length, out_ch.element_length);
        check_field("depth", 32'(want.depth), 32'(out_ch.depth));
        check_field("header_done", 32'(want.header_done), 32'(out_ch.header_done));
        check_field("is_constructed", 32'(want.is_constructed),
                    32'(out_ch.is_constructed));
        check_field("value_byte", 32'(want.value_byte), 32'(out_ch.value_byte));
        check_field("element_closed", 32'(want.element_closed),
                    32'(out_ch.element_closed));
        check_field("levels_closed", 32'(want.levels_closed), 32'(out_ch.levels_closed));
        check_field("message_status", 32'(want.message_status),
                    32'(out_ch.message_status));
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // hand-written messages at the reset markers 254 and 255
  task automatic test_directed();
    idle_on = 1'b1;
    // two-byte primitive tag, 16-bit length of two
    msg_q = '{8'h9F, 8'h21, 8'hFE, 8'h00, 8'h02, 8'h00, 8'hFF};
    send_message();
    // 32-bit length of one
    msg_q = '{8'h03, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h77};
    send_message();
    // constructed holding a zero-length primitive: both close on the last byte
    msg_q = '{8'h60, 8'h02, 8'h05, 8'h00};
    send_message();
    // constructed element with nothing inside
    msg_q = '{8'h61, 8'h00};
    send_message();
    // child value runs past its parent, then the rest is ignored
    msg_q = '{8'h62, 8'h03, 8'h01, 8'h05, 8'h00};
    send_message();
    // parent ends inside a child header
    msg_q = '{8'h62, 8'h01, 8'h81, 8'h00};
    send_message();
    // header cut short by message end
    msg_q = '{8'h02, 8'hFF};
    send_message();
    // value still open at message end
    msg_q = '{8'h01, 8'h03, 8'hAA};
    send_message();
  endtask

  task automatic test_default_markers();
    run_messages(100, 10, 1'b0);
  endtask

  // markers at the ends of their range, both ways round
  task automatic test_marker_extremes();
    set_markers(8'd0, 8'd255);
    run_messages(60, 10, 1'b0);
    set_markers(8'd255, 8'd0);
    run_messages(60, 10, 1'b0);
  endtask

  // equal markers: the 16-bit meaning takes precedence
  task automatic test_equal_markers();
    set_markers(8'h10, 8'h10);
    run_messages(60, 10, 1'b0);
  endtask

  task automatic test_random_markers();
    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_messages(60, 10, 1'b0);
  endtask

  // full stack depth and multi-level closings
  task automatic test_deep_nesting();
    set_markers(8'd254, 8'd255);
    run_messages(80, 70, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering: the block must stall
  task automatic test_backpressure();
    drain();
    hold_cycles = 150;
    run_messages(40, 10, 1'b1);
  endtask

  // back-to-back transfers, no idling on either side
  task automatic test_streaming();
    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_messages(60, 20, 1'b1);
  endtask

  initial begin
    m16 = MARKER_LEN16_RST;
    m32 = MARKER_LEN32_RST;
    clear_parse();
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_default_markers();
    test_marker_extremes();
    test_equal_markers();
    test_random_markers();
    test_deep_nesting();
    test_backpressure();
    test_streaming();

    // wait out the last reports plus the output register
    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
